>>> hdl/tcal_pkg.sv
// ----------------------------------------------------------------------------
// tcal_pkg
// Shared constants, status codes and types for the two-class alternating lock.
// ----------------------------------------------------------------------------
package tcal_pkg;

	// Waiters per class and width of a requester ID
	localparam int QUEUE_DEPTH = 16;
	localparam int ID_BITS     = 8;

	// Queue pointer, waiter count and wait-RAM address widths
	localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
	localparam int ADDR_W = $clog2(2 * QUEUE_DEPTH);
	localparam int RAM_DEPTH = 2 * QUEUE_DEPTH;

	// Result status codes
	typedef enum logic [2:0] {
		ST_GRANTED      = 3'd0,
		ST_QUEUED       = 3'd1,
		ST_HANDED       = 3'd2,
		ST_FREED        = 3'd3,
		ST_FULL         = 3'd4,
		ST_IDLE_RELEASE = 3'd5
	} status_t;

	// Operation codes
	localparam logic OP_REQUEST = 1'b0;
	localparam logic OP_RELEASE = 1'b1;

	// Owner class encoding when nobody holds the resource
	localparam logic signed [1:0] OWNER_FREE = 2'sb11;

	// Sequencer states
	typedef enum logic [1:0] {
		S_IDLE  = 2'b01,
		S_FETCH = 2'b10
	} state_t;

endpackage

>>> hdl/two_class_alternating_lock.sv
// ----------------------------------------------------------------------------
// two_class_alternating_lock
// Lock over one shared resource used by two requester classes, with one wait
// FIFO per class held in a shared RAM.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken on a rising edge where start is high and busy is low.
//   op selects acquire or release; category and requester_id go with an
//   acquire. Every request yields exactly one result, shown on status,
//   wake_valid, wake_id and owner_class for one cycle while done is high.
//   An acquire, a release that frees the resource and a release while free
//   give their result in the cycle after acceptance, and busy stays low, so
//   these run at one request per cycle. A release that hands the resource
//   to a waiter reads the waiter ID from the wait RAM, whose read data is
//   registered, so its result passes through that read register and then the
//   result registers, and busy is high for one cycle in between.
//   On a release, the oldest waiter of the other class is woken first, then
//   the oldest of the same class; with no waiters the resource goes free.
//   An acquire into a full queue is rejected with the full status.
//   Reset leaves the resource free and both queues empty; RAM contents are
//   not cleared since no entry is read before it is written.
//   The receiver cannot stall: results are presented exactly once.
// ----------------------------------------------------------------------------
module two_class_alternating_lock (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic                              op,
	input  logic                              category,
	input  logic [tcal_pkg::ID_BITS-1:0]      requester_id,
	output logic                              done,
	output logic [2:0]                        status,
	output logic                              wake_valid,
	output logic [tcal_pkg::ID_BITS-1:0]      wake_id,
	output logic signed [1:0]                 owner_class
);

	import tcal_pkg::*;

	// Control state
	state_t           state_q;
	logic             held_q;
	logic             owner_q;
	logic [PTR_W-1:0] head_q  [2];
	logic [CNT_W-1:0] count_q [2];

	// Result registers
	logic             done_q;
	status_t          status_q;
	logic             wake_valid_q;
	logic [ID_BITS-1:0] wake_id_q;

	// Decode of the incoming request
	logic             accept;
	logic             is_req;
	logic             full;
	logic             push_en;
	logic [PTR_W:0]   push_sum;
	logic [PTR_W-1:0] push_pos;
	logic             other_cls;
	logic             pick_cls;
	logic             pop_en;
	logic [PTR_W-1:0] pop_head_next;

	// RAM ports
	logic               ram_we;
	logic [ADDR_W-1:0]  ram_waddr;
	logic [ADDR_W-1:0]  ram_raddr;
	logic [ID_BITS-1:0] ram_rdata;

	assign accept = start && (state_q == S_IDLE);
	assign is_req = (op == OP_REQUEST);

	// Tail position of the requester's queue
	assign full     = (count_q[category] == CNT_W'(QUEUE_DEPTH));
	assign push_sum = {1'b0, head_q[category]} + (PTR_W + 1)'(count_q[category]);
	assign push_pos = (push_sum >= (PTR_W + 1)'(QUEUE_DEPTH))
		? PTR_W'(push_sum - (PTR_W + 1)'(QUEUE_DEPTH))
		: PTR_W'(push_sum);
	assign push_en  = accept && is_req && held_q && !full;

	// Pick the queue to wake from: other class first, then same class
	assign other_cls = ~owner_q;
	always_comb begin
		pick_cls = other_cls;
		pop_en   = 1'b0;
		if (accept && !is_req && held_q) begin
			if (count_q[other_cls] != '0) begin
				pick_cls = other_cls;
				pop_en   = 1'b1;
			end else if (count_q[owner_q] != '0) begin
				pick_cls = owner_q;
				pop_en   = 1'b1;
			end
		end
	end

	assign pop_head_next = (head_q[pick_cls] == PTR_W'(QUEUE_DEPTH - 1))
		? '0 : head_q[pick_cls] + 1'b1;

	// Queue RAM: class 1 entries sit above class 0 entries
	assign ram_we    = push_en;
	assign ram_waddr = category
		? ADDR_W'(QUEUE_DEPTH) + ADDR_W'(push_pos) : ADDR_W'(push_pos);
	assign ram_raddr = pick_cls
		? ADDR_W'(QUEUE_DEPTH) + ADDR_W'(head_q[pick_cls]) : ADDR_W'(head_q[pick_cls]);

	tcal_ram #(
		.WIDTH (ID_BITS),
		.DEPTH (RAM_DEPTH)
	) u_waitq (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (requester_id),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Sequencer, owner and queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			held_q     <= 1'b0;
			owner_q    <= 1'b0;
			head_q[0]  <= '0;
			head_q[1]  <= '0;
			count_q[0] <= '0;
			count_q[1] <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (is_req) begin
							if (!held_q) begin
								held_q  <= 1'b1;
								owner_q <= category;
							end else if (!full) begin
								count_q[category] <= count_q[category] + 1'b1;
							end
						end else if (pop_en) begin
							owner_q           <= pick_cls;
							head_q[pick_cls]  <= pop_head_next;
							count_q[pick_cls] <= count_q[pick_cls] - 1'b1;
							state_q           <= S_FETCH;
						end else begin
							held_q <= 1'b0;
						end
					end
				end
				S_FETCH: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (accept && !pop_en) || (state_q == S_FETCH);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_FETCH) begin
			status_q     <= ST_HANDED;
			wake_valid_q <= 1'b1;
			wake_id_q    <= ram_rdata;
		end else if (accept) begin
			wake_valid_q <= 1'b0;
			wake_id_q    <= '0;
			if (is_req) begin
				if (!held_q) begin
					status_q <= ST_GRANTED;
				end else if (full) begin
					status_q <= ST_FULL;
				end else begin
					status_q <= ST_QUEUED;
				end
			end else if (!held_q) begin
				status_q <= ST_IDLE_RELEASE;
			end else begin
				status_q <= ST_FREED;
			end
		end
	end

	assign busy        = (state_q != S_IDLE);
	assign done        = done_q;
	assign status      = status_q;
	assign wake_valid  = wake_valid_q;
	assign wake_id     = wake_id_q;
	assign owner_class = held_q ? $signed({1'b0, owner_q}) : OWNER_FREE;

endmodule

>>> hdl/tcal_ram.sv
// ----------------------------------------------------------------------------
// tcal_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tcal_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

>>> tb/sv/two_class_alternating_lock_tb.sv
// ----------------------------------------------------------------------------
// two_class_alternating_lock_tb
// Self-checking bench for the two-class alternating lock. A short directed
// sequence covers grant, same-class and other-class hand-over, freeing,
// release while free and both ID extremes. Random fill and drain bursts then
// push the wait queues from empty to full and back. Every accepted request is
// run through a local model of the lock, and each result is checked field by
// field against the oldest predicted outcome.
// ----------------------------------------------------------------------------
module two_class_alternating_lock_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import tcal_pkg::*;

	localparam int NUM_REQUESTS = 1550;
	localparam int CALM_TAIL    = 150;   // final requests issued back to back
	localparam int STALL_LIMIT  = 1000;  // cycles without any handshake
	localparam int DRAIN_CYCLES = 8;

	typedef struct packed {
		logic                op;
		logic                category;
		logic [ID_BITS-1:0]  id;
	} lock_request_t;

	typedef struct packed {
		status_t             status;
		logic                wake_valid;
		logic [ID_BITS-1:0]  wake_id;
		logic signed [1:0]   owner;
	} lock_outcome_t;

	logic                clk          = 1'b0;
	logic                arst_n       = 1'b0;
	logic                start        = 1'b0;
	logic                op           = 1'b0;
	logic                category     = 1'b0;
	logic [ID_BITS-1:0]  requester_id = '0;
	logic                busy;
	logic                done;
	logic [2:0]          status;
	logic                wake_valid;
	logic [ID_BITS-1:0]  wake_id;
	logic signed [1:0]   owner_class;

	lock_request_t  requests_pending[$];
	lock_outcome_t  outcomes_due[$];

	// local copy of the lock state
	logic signed [1:0]   lock_owner = OWNER_FREE;
	logic [ID_BITS-1:0]  waiters [2][QUEUE_DEPTH];
	int                  waiter_head  [2] = '{0, 0};
	int                  waiter_count [2] = '{0, 0};

	int mismatches   = 0;
	int accepted     = 0;
	int results_seen = 0;
	int status_seen [6] = '{0, 0, 0, 0, 0, 0};
	int idle_left    = 0;
	int quiet_cycles = 0;

	two_class_alternating_lock u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.op           (op),
		.category     (category),
		.requester_id (requester_id),
		.done         (done),
		.status       (status),
		.wake_valid   (wake_valid),
		.wake_id      (wake_id),
		.owner_class  (owner_class)
	);

	always #2 clk = ~clk;

	// Apply one request to the local lock state and return its outcome
	function automatic lock_outcome_t apply_lock_request(lock_request_t r);
		lock_outcome_t res;
		int            cur;
		int            other;
		int            pick;
		res.status     = ST_GRANTED;
		res.wake_valid = 1'b0;
		res.wake_id    = '0;
		if (r.op == OP_REQUEST) begin
			if (lock_owner == OWNER_FREE) begin
				lock_owner = {1'b0, r.category};
				res.status = ST_GRANTED;
			end else if (waiter_count[r.category] >= QUEUE_DEPTH) begin
				res.status = ST_FULL;
			end else begin
				waiters[r.category][(waiter_head[r.category] + waiter_count[r.category])
					% QUEUE_DEPTH] = r.id;
				waiter_count[r.category]++;
				res.status = ST_QUEUED;
			end
		end else if (lock_owner == OWNER_FREE) begin
			res.status = ST_IDLE_RELEASE;
		end else begin
			// other class first, then same class, else go free
			cur   = int'(lock_owner[0]);
			other = 1 - cur;
			if (waiter_count[other] > 0)
				pick = other;
			else if (waiter_count[cur] > 0)
				pick = cur;
			else
				pick = -1;
			if (pick < 0) begin
				lock_owner = OWNER_FREE;
				res.status = ST_FREED;
			end else begin
				res.wake_id        = waiters[pick][waiter_head[pick]];
				res.wake_valid     = 1'b1;
				waiter_head[pick]  = (waiter_head[pick] + 1) % QUEUE_DEPTH;
				waiter_count[pick]--;
				lock_owner         = {1'b0, pick[0]};
				res.status         = ST_HANDED;
			end
		end
		res.owner = lock_owner;
		return res;
	endfunction

	task automatic flag_mismatch(input string msg);
		mismatches++;
		$display("[%0t] MISMATCH: %s", $time, msg);
	endtask

	task automatic add_request(input logic r_op, input logic r_cat, input logic [7:0] r_id);
		lock_request_t r;
		r.op       = r_op;
		r.category = r_cat;
		r.id       = r_id;
		requests_pending.push_back(r);
	endtask

	// Driver: predict on acceptance, then present the next request or idle
	always @(posedge clk or negedge arst_n) begin
		lock_request_t nxt;
		if (!arst_n) begin
			start        <= 1'b0;
			op           <= 1'b0;
			category     <= 1'b0;
			requester_id <= '0;
		end else begin
			if (start && !busy) begin
				nxt.op       = op;
				nxt.category = category;
				nxt.id       = requester_id;
				outcomes_due.push_back(apply_lock_request(nxt));
				accepted++;
			end
			if (!start || !busy) begin
				if (idle_left > 0) begin
					idle_left--;
					start <= 1'b0;
				end else if (requests_pending.size() > 0) begin
					nxt = requests_pending.pop_front();
					op           <= nxt.op;
					category     <= nxt.category;
					requester_id <= nxt.id;
					start        <= 1'b1;
					if (requests_pending.size() > CALM_TAIL && $urandom_range(0, 4) == 0)
						idle_left = $urandom_range(1, 6);
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Monitor: check each result strobe against the oldest expectation
	always @(posedge clk) begin
		lock_outcome_t exp_o;
		if (arst_n && done) begin
			results_seen++;
			if (outcomes_due.size() == 0) begin
				flag_mismatch($sformatf("result with nothing expected, status %0d", status));
			end else begin
				exp_o = outcomes_due.pop_front();
				status_seen[exp_o.status]++;
				if (status !== exp_o.status)
					flag_mismatch($sformatf("status %0d, expected %0d", status, exp_o.status));
				if (wake_valid !== exp_o.wake_valid)
					flag_mismatch($sformatf("wake_valid %b, expected %b",
						wake_valid, exp_o.wake_valid));
				if (wake_id !== exp_o.wake_id)
					flag_mismatch($sformatf("wake_id %0h, expected %0h", wake_id, exp_o.wake_id));
				if (owner_class !== exp_o.owner)
					flag_mismatch($sformatf("owner_class %0d, expected %0d",
						owner_class, exp_o.owner));
			end
		end
	end

	// Watchdog on handshake activity
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("watchdog expired with %0d results outstanding", outcomes_due.size());
				$display("simulation failed");
				$finish;
			end
		end
	end

	// Stimulus and end of run
	initial begin
		int kind;
		int n;
		int mix;
		logic cat;

		// directed: release while free, both hand-over orders, freeing
		add_request(OP_RELEASE, 1'b1, 8'hFF);
		add_request(OP_REQUEST, 1'b0, 8'h00);
		add_request(OP_REQUEST, 1'b0, 8'hFF);  // same class while held: waits
		add_request(OP_REQUEST, 1'b1, 8'hAA);
		add_request(OP_REQUEST, 1'b1, 8'h55);
		add_request(OP_RELEASE, 1'b0, 8'h00);  // to class 1
		add_request(OP_RELEASE, 1'b1, 8'h00);  // back to class 0
		add_request(OP_RELEASE, 1'b0, 8'hFF);  // to class 1 again
		add_request(OP_RELEASE, 1'b0, 8'h00);  // nobody waits: free
		add_request(OP_RELEASE, 1'b0, 8'h00);  // release while free
		add_request(OP_REQUEST, 1'b1, 8'h01);
		add_request(OP_REQUEST, 1'b1, 8'hFE);
		add_request(OP_RELEASE, 1'b1, 8'h01);  // same class only: stays with 1
		add_request(OP_RELEASE, 1'b1, 8'h01);
		add_request(OP_REQUEST, 1'b1, 8'h80);
		add_request(OP_REQUEST, 1'b0, 8'h7F);
		add_request(OP_RELEASE, 1'b0, 8'h00);
		add_request(OP_RELEASE, 1'b0, 8'h00);

		// random fill and drain bursts so both queues swing empty to full
		while (requests_pending.size() < NUM_REQUESTS) begin
			kind = $urandom_range(0, 9);
			if (kind < 5) begin
				n   = $urandom_range(1, 22);
				mix = $urandom_range(0, 2);
				repeat (n) begin
					cat = (mix == 2) ? 1'($urandom_range(0, 1)) : mix[0];
					add_request(OP_REQUEST, cat, 8'($urandom));
				end
			end else if (kind < 9) begin
				n = $urandom_range(1, 28);
				repeat (n)
					add_request(OP_RELEASE, 1'($urandom_range(0, 1)), 8'($urandom));
			end else begin
				n = $urandom_range(1, 6);
				repeat (n)
					add_request(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
						8'($urandom));
			end
		end

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (requests_pending.size() != 0 || start)
			@(posedge clk);
		while (outcomes_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (outcomes_due.size() != 0)
			flag_mismatch($sformatf("%0d results never arrived", outcomes_due.size()));
		$display("%0d requests, %0d results: granted %0d, queued %0d, handed over %0d",
			accepted, results_seen, status_seen[ST_GRANTED], status_seen[ST_QUEUED],
			status_seen[ST_HANDED]);
		$display("freed %0d, rejected on full queue %0d, release while free %0d",
			status_seen[ST_FREED], status_seen[ST_FULL], status_seen[ST_IDLE_RELEASE]);
		if (mismatches == 0) begin
			$display("simulation ok");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("simulation failed");
		end
		$finish;
	end

endmodule

>>> sim.f
hdl/tcal_pkg.sv
hdl/tcal_ram.sv
hdl/two_class_alternating_lock.sv
tb/sv/two_class_alternating_lock_tb.sv
